FILE: hdl/accounting_record_encoder_core_defines.svh
// assertion macros for the accounting record encoder core
// used by hdl/accounting_record_encoder_core.sv; relies on clk and rst_n in scope
`ifndef ACCOUNTING_RECORD_ENCODER_CORE_DEFINES_SVH
`define ACCOUNTING_RECORD_ENCODER_CORE_DEFINES_SVH

// condition must hold in the same cycle
`define ACE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accounting encoder: same-cycle check failed");

// condition must hold in the next cycle
`define ACE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accounting encoder: next-cycle check failed");

`endif

FILE: hdl/acct_enc_pkg.sv
// shared types, constants and the comp_t packing function
// for the accounting record encoder; no dependencies
`default_nettype none

package acct_enc_pkg;

    // comp_t layout: 13-bit mantissa under a 3-bit base-8 exponent
    localparam int unsigned MANT_BITS  = 13;
    localparam int unsigned EXP_BITS   = 3;
    localparam int unsigned EXP_LEVELS = 1 << EXP_BITS;
    localparam int unsigned CODE_W     = MANT_BITS + EXP_BITS;

    typedef logic [CODE_W-1:0] comp_code_t;

    localparam logic [31:0]  MANT_LIMIT = 32'(1) << MANT_BITS;
    localparam comp_code_t   CODE_OVERFLOW = '1;
    localparam logic [15:0]  NO_TTY = 16'hFFFF;

    // register map
    localparam logic REG_TICK_RATE   = 1'b0;
    localparam logic REG_WAKE_THRESH = 1'b1;

    localparam logic [9:0]  TICK_RATE_RESET   = 10'd60;
    localparam logic [14:0] WAKE_THRESH_RESET = 15'd10;

    // truncating pack of a 32-bit value into comp_t, all ones on overflow
    function automatic comp_code_t pack_code(input logic [31:0] v);
        logic [31:0] s;
        comp_code_t  code;
        logic        found;
        code  = CODE_OVERFLOW;
        found = 1'b0;
        s     = v;
        for (int e = 0; e < EXP_LEVELS; e++)
        begin
            if (!found && (s < MANT_LIMIT))
            begin
                code  = {EXP_BITS'(e), s[MANT_BITS-1:0]};
                found = 1'b1;
            end
            s = s >> EXP_BITS;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/accounting_record_encoder_core.sv
// accounting record encoder: one process-exit transaction in, one record out
// depends on acct_enc_pkg and accounting_record_encoder_core_defines.svh
//
//   channel   direction  signals                          accepted when
//   in        input      in_valid/in_ready + 11 fields    in_valid && in_ready
//   out       output     out_valid/out_ready + 8 fields   out_valid && out_ready
//   cfg       input      APB psel/penable/pwrite/paddr    psel && penable && pwrite
//
// each transaction runs from acceptance to the result register through the
// scaling of all working values on the shared multiplier, then two passes
// (2 quotient bits per cycle) of the shared divider, plus load/store steps
// in_ready is high only while the sequencer is idle, so a transaction is not
// accepted until the previous one has been loaded into the output register
// a finished result waits in the output register; the next transaction may
// be accepted and worked on meanwhile, the sequencer only holds at its last
// step while the output register is still full
// rst_n is asynchronous: clears sequencer, valid and counter, presets the config registers
`default_nettype none
`include "accounting_record_encoder_core_defines.svh"

module accounting_record_encoder_core #(
    parameter int unsigned TIME_SCALE = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] user_ticks,
    input  wire logic [31:0] sys_ticks,
    input  wire logic [31:0] now_seconds,
    input  wire logic [31:0] start_seconds,
    input  wire logic [31:0] in_blocks,
    input  wire logic [31:0] out_blocks,
    input  wire logic [10:0] data_clicks,
    input  wire logic [10:0] stack_clicks,
    input  wire logic        has_tty,
    input  wire logic [15:0] tty_device,
    input  wire logic [7:0]  acct_flags,

    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      user_time_code,
    output logic [15:0]      sys_time_code,
    output logic [15:0]      elapsed_code,
    output logic [15:0]      io_code,
    output logic [7:0]       memory_kb,
    output logic [15:0]      tty_out,
    output logic [7:0]       flags_out,
    output logic             wake_daemon
);

    localparam logic [31:0] SCALE_W   = 32'(TIME_SCALE);
    localparam int unsigned DIV_STEPS = 32 / 2;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DLOAD  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_DSTORE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mul_cnt_reg, mul_cnt_next;
    logic              div_sel_reg, div_sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // configuration registers
    logic [9:0]  tick_rate_reg;
    logic [14:0] wake_thresh_reg;
    logic        cfg_write;

    // working values: user, system, elapsed, io
    logic [31:0] val_reg [4];
    logic [7:0]  mem_hold_reg;
    logic [15:0] tty_hold_reg;
    logic [7:0]  flags_hold_reg;

    // shared divider
    logic [31:0] divq_reg;
    logic [9:0]  rem_reg;
    logic [9:0]  div_reg;
    logic [9:0]  div_eff;
    logic [10:0] t1, t2;
    logic        ge1, ge2;
    logic [9:0]  r1, r2;

    logic [31:0] mul_prod;

    // output register and record counter
    logic        out_valid_reg;
    logic        out_load;
    logic [15:0] record_count_reg;
    logic [15:0] count_inc;
    logic        wake_hit;
    acct_enc_pkg::comp_code_t user_code_reg, sys_code_reg, elapsed_code_reg, io_code_reg;
    logic [7:0]  memory_kb_reg;
    logic [15:0] tty_out_reg;
    logic [7:0]  flags_out_reg;
    logic        wake_daemon_reg;

    logic        in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign pready   = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg   <= acct_enc_pkg::TICK_RATE_RESET;
            wake_thresh_reg <= acct_enc_pkg::WAKE_THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                acct_enc_pkg::REG_TICK_RATE:   tick_rate_reg   <= pwdata[9:0];
                acct_enc_pkg::REG_WAKE_THRESH: wake_thresh_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            acct_enc_pkg::REG_TICK_RATE:   prdata = {22'd0, tick_rate_reg};
            acct_enc_pkg::REG_WAKE_THRESH: prdata = {17'd0, wake_thresh_reg};
            default:                       prdata = '0;
        endcase
    end

    // zero tick rate divides as one
    assign div_eff = (tick_rate_reg == 10'd0) ? 10'd1 : tick_rate_reg;

    // two restoring division steps per cycle
    always_comb
    begin
        t1  = {rem_reg, divq_reg[31]};
        ge1 = (t1 >= {1'b0, div_reg});
        r1  = ge1 ? 10'(t1 - {1'b0, div_reg}) : t1[9:0];
        t2  = {r1, divq_reg[30]};
        ge2 = (t2 >= {1'b0, div_reg});
        r2  = ge2 ? 10'(t2 - {1'b0, div_reg}) : t2[9:0];
    end

    // shared scaling multiplier, 32-bit wrap
    assign mul_prod = 32'(val_reg[mul_cnt_reg] * SCALE_W);

    // output load and record counter
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign count_inc = record_count_reg + 16'd1;
    assign wake_hit  = (count_inc >= {1'b0, wake_thresh_reg});

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        mul_cnt_next = mul_cnt_reg;
        div_sel_next = div_sel_reg;
        step_next    = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next   = ST_MUL;
                    mul_cnt_next = 2'd0;
                end
            end
            ST_MUL:
            begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next   = ST_DLOAD;
                    div_sel_next = 1'b0;
                end
            end
            ST_DLOAD:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE:
            begin
                if (div_sel_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next   = ST_DLOAD;
                    div_sel_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mul_cnt_reg      <= '0;
            div_sel_reg      <= 1'b0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            record_count_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
            div_sel_reg <= div_sel_next;
            step_reg    <= step_next;
            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                record_count_reg <= wake_hit ? 16'd0 : count_inc;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: capture, scale, divide
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            val_reg[0]     <= user_ticks;
            val_reg[1]     <= sys_ticks;
            val_reg[2]     <= now_seconds - start_seconds;
            val_reg[3]     <= in_blocks + out_blocks;
            mem_hold_reg   <= 8'(({1'b0, data_clicks} + {1'b0, stack_clicks}) >> 4);
            tty_hold_reg   <= has_tty ? tty_device : acct_enc_pkg::NO_TTY;
            flags_hold_reg <= acct_flags;
        end
        else if (state_reg == ST_MUL)
        begin
            val_reg[mul_cnt_reg] <= mul_prod;
        end
        else if (state_reg == ST_DSTORE)
        begin
            val_reg[{1'b0, div_sel_reg}] <= divq_reg;
        end

        if (state_reg == ST_DLOAD)
        begin
            divq_reg <= val_reg[{1'b0, div_sel_reg}];
            rem_reg  <= '0;
            div_reg  <= div_eff;
        end
        else if (state_reg == ST_DIV)
        begin
            divq_reg <= {divq_reg[29:0], ge1, ge2};
            rem_reg  <= r2;
        end
    end

    // result register, packed at load
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            user_code_reg    <= acct_enc_pkg::pack_code(val_reg[0]);
            sys_code_reg     <= acct_enc_pkg::pack_code(val_reg[1]);
            elapsed_code_reg <= acct_enc_pkg::pack_code(val_reg[2]);
            io_code_reg      <= acct_enc_pkg::pack_code(val_reg[3]);
            memory_kb_reg    <= mem_hold_reg;
            tty_out_reg      <= tty_hold_reg;
            flags_out_reg    <= flags_hold_reg;
            wake_daemon_reg  <= wake_hit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign user_time_code = user_code_reg;
    assign sys_time_code  = sys_code_reg;
    assign elapsed_code   = elapsed_code_reg;
    assign io_code        = io_code_reg;
    assign memory_kb      = memory_kb_reg;
    assign tty_out        = tty_out_reg;
    assign flags_out      = flags_out_reg;
    assign wake_daemon    = wake_daemon_reg;

    // checks
    `ACE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ACE_ASSERT_NOW(a_div_rem_bound, state_reg == ST_DIV, rem_reg < div_reg)
    `ACE_ASSERT_NOW(a_wake_clears_count, out_valid_reg && wake_daemon_reg, record_count_reg == 16'd0)
    `ACE_ASSERT_NEXT(a_finish_loads_output, state_reg == ST_FINISH && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE)

endmodule

`default_nettype wire

FILE: tb/accounting_record_encoder_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for accounting_record_encoder_core: directed and random
// process-exit transactions, each checked against an in-bench record predictor
// depends on acct_enc_pkg and the accounting_record_encoder_core RTL

module accounting_record_encoder_core_tb;

    localparam int unsigned SCALE         = 64;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 150;

    // one process-exit transaction
    typedef struct packed {
        logic [31:0] user_ticks;
        logic [31:0] sys_ticks;
        logic [31:0] now_seconds;
        logic [31:0] start_seconds;
        logic [31:0] in_blocks;
        logic [31:0] out_blocks;
        logic [10:0] data_clicks;
        logic [10:0] stack_clicks;
        logic        has_tty;
        logic [15:0] tty_device;
        logic [7:0]  acct_flags;
    } exit_rec_t;

    // one accounting record
    typedef struct packed {
        logic [15:0] user_code;
        logic [15:0] sys_code;
        logic [15:0] elapsed;
        logic [15:0] io;
        logic [7:0]  mem_kb;
        logic [15:0] tty;
        logic [7:0]  flags;
        logic        wake;
    } acct_record_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] user_ticks;
    logic [31:0] sys_ticks;
    logic [31:0] now_seconds;
    logic [31:0] start_seconds;
    logic [31:0] in_blocks;
    logic [31:0] out_blocks;
    logic [10:0] data_clicks;
    logic [10:0] stack_clicks;
    logic        has_tty;
    logic [15:0] tty_device;
    logic [7:0]  acct_flags;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] user_time_code;
    logic [15:0] sys_time_code;
    logic [15:0] elapsed_code;
    logic [15:0] io_code;
    logic [7:0]  memory_kb;
    logic [15:0] tty_out;
    logic [7:0]  flags_out;
    logic        wake_daemon;

    // predictor state and configuration
    logic [9:0]   rate_setting;
    logic [14:0]  wake_limit;
    logic [15:0]  records_since_wake;

    acct_record_t pending_records[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           no_idle = 1'b0;

    accounting_record_encoder_core #(
        .TIME_SCALE(SCALE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .user_ticks    (user_ticks),
        .sys_ticks     (sys_ticks),
        .now_seconds   (now_seconds),
        .start_seconds (start_seconds),
        .in_blocks     (in_blocks),
        .out_blocks    (out_blocks),
        .data_clicks   (data_clicks),
        .stack_clicks  (stack_clicks),
        .has_tty       (has_tty),
        .tty_device    (tty_device),
        .acct_flags    (acct_flags),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .user_time_code(user_time_code),
        .sys_time_code (sys_time_code),
        .elapsed_code  (elapsed_code),
        .io_code       (io_code),
        .memory_kb     (memory_kb),
        .tty_out       (tty_out),
        .flags_out     (flags_out),
        .wake_daemon   (wake_daemon)
    );

    // clock
    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // comp_t: shift out octal digits until the mantissa fits in 13 bits
    function automatic logic [15:0] comp_encode(input logic [31:0] value);
        logic [31:0] mant;
        int          expo;
        mant = value;
        expo = 0;
        while (mant >= 32'h2000 && expo < 8)
        begin
            mant = mant >> 3;
            expo++;
        end
        if (expo > 7)
            return 16'hFFFF;
        return {expo[2:0], mant[12:0]};
    endfunction

    // expected record for one accepted transaction, advances the record counter
    task automatic predict_record(input exit_rec_t x, output acct_record_t r);
        logic [31:0] divisor;
        logic [31:0] user_scaled;
        logic [31:0] sys_scaled;
        logic [31:0] elapsed_scaled;
        logic [31:0] blocks_scaled;
        logic [11:0] click_sum;
        divisor        = (rate_setting == '0) ? 32'd1 : {22'b0, rate_setting};
        user_scaled    = x.user_ticks * 32'(SCALE);
        sys_scaled     = x.sys_ticks * 32'(SCALE);
        elapsed_scaled = (x.now_seconds - x.start_seconds) * 32'(SCALE);
        blocks_scaled  = (x.in_blocks + x.out_blocks) * 32'(SCALE);
        click_sum      = {1'b0, x.data_clicks} + {1'b0, x.stack_clicks};
        r.user_code = comp_encode(user_scaled / divisor);
        r.sys_code  = comp_encode(sys_scaled / divisor);
        r.elapsed   = comp_encode(elapsed_scaled);
        r.io        = comp_encode(blocks_scaled);
        r.mem_kb    = click_sum[11:4];
        r.tty       = x.has_tty ? x.tty_device : acct_enc_pkg::NO_TTY;
        r.flags     = x.acct_flags;
        records_since_wake = records_since_wake + 16'd1;
        if (records_since_wake >= {1'b0, wake_limit})
        begin
            r.wake = 1'b1;
            records_since_wake = '0;
        end
        else
            r.wake = 1'b0;
    endtask

    function automatic int pick_wait();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic exit_rec_t exit_item(
        input logic [31:0] user, input logic [31:0] sys,
        input logic [31:0] now, input logic [31:0] start,
        input logic [31:0] inb, input logic [31:0] outb,
        input logic [10:0] dcl, input logic [10:0] scl,
        input logic tty_on, input logic [15:0] ttyd, input logic [7:0] flags);
        exit_rec_t x;
        x.user_ticks    = user;
        x.sys_ticks     = sys;
        x.now_seconds   = now;
        x.start_seconds = start;
        x.in_blocks     = inb;
        x.out_blocks    = outb;
        x.data_clicks   = dcl;
        x.stack_clicks  = scl;
        x.has_tty       = tty_on;
        x.tty_device    = ttyd;
        x.acct_flags    = flags;
        return x;
    endfunction

    // mix of small, partly shifted and full-width counts
    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 300);
            1: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic exit_rec_t random_exit();
        exit_rec_t x;
        x.user_ticks  = pick_count();
        x.sys_ticks   = pick_count();
        x.now_seconds = $urandom;
        // mostly a start before now, sometimes anything
        if ($urandom_range(0, 4) != 0)
            x.start_seconds = x.now_seconds - ($urandom >> $urandom_range(4, 31));
        else
            x.start_seconds = $urandom;
        x.in_blocks    = pick_count();
        x.out_blocks   = pick_count();
        x.data_clicks  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, 1024);
        x.stack_clicks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, 1024);
        x.has_tty      = $urandom_range(0, 1);
        x.tty_device   = $urandom_range(0, 65535);
        x.acct_flags   = $urandom_range(0, 255);
        return x;
    endfunction

    // send one transaction, predict its record once it is accepted
    task automatic send_exit(input exit_rec_t x);
        int           gap;
        acct_record_t exp_rec;
        gap = pick_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        user_ticks    <= x.user_ticks;
        sys_ticks     <= x.sys_ticks;
        now_seconds   <= x.now_seconds;
        start_seconds <= x.start_seconds;
        in_blocks     <= x.in_blocks;
        out_blocks    <= x.out_blocks;
        data_clicks   <= x.data_clicks;
        stack_clicks  <= x.stack_clicks;
        has_tty       <= x.has_tty;
        tty_device    <= x.tty_device;
        acct_flags    <= x.acct_flags;
        do @(posedge clk); while (!in_ready);
        predict_record(x, exp_rec);
        pending_records.push_back(exp_rec);
    endtask

    // stop sending, let all records drain and the sequencer settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access cycle, then the bus returns to idle
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == acct_enc_pkg::REG_TICK_RATE)
            rate_setting = value[9:0];
        else
            wake_limit = value[14:0];
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // record checker with random back-pressure
    initial
    begin
        int           stall;
        acct_record_t exp_rec;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_wait();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_records.size() == 0)
            begin
                $error("record received with no transaction outstanding");
                error_count++;
            end
            else
            begin
                exp_rec = pending_records.pop_front();
                check_field("user_time_code", exp_rec.user_code, user_time_code);
                check_field("sys_time_code", exp_rec.sys_code, sys_time_code);
                check_field("elapsed_code", exp_rec.elapsed, elapsed_code);
                check_field("io_code", exp_rec.io, io_code);
                check_field("memory_kb", {8'b0, exp_rec.mem_kb}, {8'b0, memory_kb});
                check_field("tty_out", exp_rec.tty, tty_out);
                check_field("flags_out", {8'b0, exp_rec.flags}, {8'b0, flags_out});
                check_field("wake_daemon", {15'b0, exp_rec.wake}, {15'b0, wake_daemon});
            end
        end
    end

    // field extremes, wraps and comp_t boundaries under reset configuration
    task automatic test_field_extremes();
        send_exit(exit_item('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0));
        send_exit(exit_item('1, '1, '1, '0, '1, '1, 11'd1024, 11'd1024,
                            1'b1, 16'hFFFF, 8'hFF));
        // oversized clicks, no terminal
        send_exit(exit_item(32'd60, 32'd59, 32'd100, 32'd99, 32'd1, 32'd0,
                            11'd2047, 11'd2047, 1'b0, 16'h1234, 8'h5A));
        // start after now wraps
        send_exit(exit_item(32'd1, 32'd2, 32'd5, 32'd10, 32'd0, 32'd0,
                            11'd15, 11'd1, 1'b1, 16'h0000, 8'hA5));
        // mantissa edge: 127 and 128 seconds scaled
        send_exit(exit_item(32'd7679, 32'd7680, 32'd127, 32'd0, 32'd64, 32'd64,
                            11'd16, 11'd0, 1'b1, 16'h8001, 8'h01));
        send_exit(exit_item(32'd7678, 32'd7681, 32'd128, 32'd0, 32'hFFFF_FFFF, 32'd1,
                            11'd0, 11'd17, 1'b0, 16'h7FFE, 8'h80));
        // scaling wrap of tick counts
        send_exit(exit_item(32'h0400_0000, 32'h03FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h0200_0000, 32'h01FF_FFFF, 11'd1023, 11'd1, 1'b1,
                            16'h00FF, 8'h7F));
        repeat (3) send_exit(random_exit());
    endtask

    // zero rate divides by one, rate 1000, top rate as all ones with garbage above
    task automatic test_tick_rate_edges();
        wait_idle();
        write_reg(acct_enc_pkg::REG_TICK_RATE, 32'd0);
        send_exit(exit_item(32'd1000, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd5, 32'd6,
                            11'd32, 11'd32, 1'b1, 16'h0042, 8'h3C));
        send_exit(random_exit());
        wait_idle();
        write_reg(acct_enc_pkg::REG_TICK_RATE, 32'd1000);
        send_exit(exit_item(32'hFFFF_FFFF, 32'd999, 32'd0, 32'd0, 32'd0, 32'd0,
                            11'd0, 11'd0, 1'b0, 16'hFFFF, 8'h00));
        send_exit(random_exit());
        wait_idle();
        write_reg(acct_enc_pkg::REG_TICK_RATE, 32'hFFFF_FFFF);
        send_exit(random_exit());
    endtask

    // zero threshold wakes every record, then a threshold lowered below the count
    task automatic test_wake_threshold_edges();
        wait_idle();
        write_reg(acct_enc_pkg::REG_WAKE_THRESH, 32'd0);
        repeat (2) send_exit(random_exit());
        wait_idle();
        write_reg(acct_enc_pkg::REG_WAKE_THRESH, 32'd20);
        repeat (4) send_exit(random_exit());
        wait_idle();
        write_reg(acct_enc_pkg::REG_WAKE_THRESH, 32'd2);
        send_exit(random_exit());
    endtask

    // random traffic over several register settings
    task automatic test_random_traffic();
        logic [31:0] rate_val;
        logic [31:0] thresh_val;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: rate_val = 32'd1;
                1: rate_val = 32'd1000;
                2: rate_val = 32'd0;
                3: rate_val = 32'd60;
                default: rate_val = $urandom_range(1, 1000) | ($urandom & 32'hFFFF_FC00);
            endcase
            case (phase)
                0: thresh_val = 32'd1;
                1: thresh_val = 32'd32767;
                2: thresh_val = $urandom_range(0, 40);
                3: thresh_val = 32'd0;
                default: thresh_val = $urandom;
            endcase
            write_reg(acct_enc_pkg::REG_TICK_RATE, rate_val);
            write_reg(acct_enc_pkg::REG_WAKE_THRESH, thresh_val);
            no_idle = (phase % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_exit(random_exit());
        end
        no_idle = 1'b0;
    endtask

    // reset, then the tests in turn
    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        user_ticks    <= '0;
        sys_ticks     <= '0;
        now_seconds   <= '0;
        start_seconds <= '0;
        in_blocks     <= '0;
        out_blocks    <= '0;
        data_clicks   <= '0;
        stack_clicks  <= '0;
        has_tty       <= 1'b0;
        tty_device    <= '0;
        acct_flags    <= '0;
        rate_setting       = acct_enc_pkg::TICK_RATE_RESET;
        wake_limit         = acct_enc_pkg::WAKE_THRESH_RESET;
        records_since_wake = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_tick_rate_edges();
        test_wake_threshold_edges();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
